FILE: rtl/gb3_pkg.sv
package gb3_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 3;
  localparam int MAX_HEIGHT   = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int CH_W  = $clog2(MAX_CHANNELS);

  localparam int FWIDTH_W  = 12;
  localparam int FHEIGHT_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  localparam logic [COL_W-1:0]     RESET_W_LAST = COL_W'(640 - 1);
  localparam logic [FHEIGHT_W-1:0] RESET_HEIGHT = FHEIGHT_W'(480);

  // one window column: [0] top, [1] middle, [2] bottom
  typedef logic [2:0][7:0] colv_t;

  typedef struct packed {
    logic             drain;
    logic [7:0]       sample;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  ch;
    logic             emit;
    logic             last;
    logic             rep_top;
    logic             left_right_col;
    logic             right_new;
  } s1_ctl_t;

  function automatic logic [9:0] col_weight(input colv_t v, input logic rep_top);
    logic [7:0] t;
    t = rep_top ? v[1] : v[0];
    return 10'(t) + {1'b0, v[1], 1'b0} + 10'(v[2]);
  endfunction

  function automatic logic [7:0] blur(input colv_t l, input colv_t c, input colv_t r,
                                      input logic rep_top);
    logic [11:0] sum;
    sum = 12'(col_weight(l, rep_top)) + {1'b0, col_weight(c, rep_top), 1'b0}
        + 12'(col_weight(r, rep_top)) + 12'd8;
    return sum[11:4];
  endfunction

endpackage

FILE: rtl/gb3_if.sv
interface gb3_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] sample_in;
  modport source (output valid, req_type, sample_in, input ready);
  modport sink   (input valid, req_type, sample_in, output ready);
endinterface

interface gb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_out;
  logic       frame_end;
  modport source (output valid, sample_out, frame_end, input ready);
  modport sink   (input valid, sample_out, frame_end, output ready);
endinterface

interface gb3_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [12:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/gaussian_blur_3x3_stream_unit.sv
// Streaming 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, rounded by +8 >> 4).
// Channels:
//   in_ch  : req_type 0 carries one 8-bit sample (raster order, channels
//            interleaved); req_type 1 is a drain tick sent after the last sample.
//   out_ch : blurred sample_out, frame_end marks the last result of a frame.
//   cfg    : register writes (0 frame_width, 1 frame_height, 2 color_mode),
//            always ready; a listed write stores the value and restarts the frame.
// Throughput: one transfer per clock on in_ch while out_ch is taken.
// Path: a result passes from the in_ch transfer behind it through the stage 1
// register and the result register to out_ch; the result for pixel p is caused by
// input pixel p + width + 1, and (width + 1) * channels drain ticks push out
// the tail of the frame. The line stores set the rate: each takes one read for
// the arriving item and one write for the item in the stage register per clock.
// Reset: registers go to 640 x 480 gray, position and window clear; line
// stores need no clearing, edge replication hides unwritten entries.
// Stall: when out_ch is not ready the result register holds, the middle
// stage holds behind it, and if full, in_ch drops ready until the result is taken.
module gaussian_blur_3x3_stream_unit
  import gb3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gb3_in_if.sink      in_ch,
  gb3_out_if.source   out_ch,
  gb3_cfg_if.sink     cfg
);

  // configuration, kept already clamped
  logic [COL_W-1:0]     w_last;   // effective width - 1
  logic [FHEIGHT_W-1:0] height;   // effective height 1..4096
  logic                 color;

  // position of the next item
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [CH_W-1:0]  ch_pos;

  // stage 1
  logic              s1_valid;
  s1_ctl_t           s1;
  logic              s1_fwd;
  logic [7:0]        s1_fwd_top;
  logic [7:0]        s1_fwd_mid;
  logic [7:0]        rd_top;
  logic [7:0]        rd_mid;

  // result register
  logic       out_valid;
  logic [7:0] out_sample;
  logic       out_last;

  // line stores and per-channel windows (columns 0 left .. 2 right)
  logic [7:0] upper_mem  [LINE_DEPTH];
  logic [7:0] middle_mem [LINE_DEPTH];
  colv_t      win [MAX_CHANNELS][3];

  logic in_xfer, s1_adv, cfg_xfer;

  assign cfg.ready  = 1'b1;
  assign cfg_xfer   = cfg.valid;
  assign s1_adv     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_xfer    = in_ch.valid && in_ch.ready;

  // ---------------- stage 0: position and addressing ----------------
  logic             is_drain, frame_done, ignore;
  logic [COL_W-1:0] c_col;
  logic [ROW_W-1:0] c_row;
  logic [CH_W-1:0]  c_ch;
  logic [CH_W-1:0]  ch_max;
  logic [IDX_W-1:0] idx;
  logic             emit_c0, emit_cn, last;
  logic [ROW_W-1:0] h_ext;
  s1_ctl_t          s0;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [CH_W-1:0]  ch_next;

  always_comb begin
    h_ext      = ROW_W'(height);
    is_drain   = (in_ch.req_type == REQ_DRAIN);
    frame_done = (row_pos >= h_ext);
    ignore     = is_drain && !frame_done;
    // a sample after the frame is complete starts a new frame
    if (!is_drain && frame_done) begin
      c_col = '0;
      c_row = '0;
      c_ch  = '0;
    end else begin
      c_col = col_pos;
      c_row = row_pos;
      c_ch  = ch_pos;
    end
    ch_max = color ? CH_W'(MAX_CHANNELS - 1) : '0;
    if (color) begin
      idx = {1'b0, c_col, 1'b0} + IDX_W'(c_col) + IDX_W'(c_ch);
    end else begin
      idx = IDX_W'(c_col);
    end
    emit_c0 = (c_col == '0) && (c_row >= ROW_W'(2));
    emit_cn = (c_col != '0) && (c_row != '0);
    last    = (c_col == '0) && (c_row == h_ext + ROW_W'(1)) && (c_ch == ch_max);

    s0.drain          = is_drain;
    s0.sample         = in_ch.sample_in;
    s0.idx            = idx;
    s0.ch             = c_ch;
    s0.emit           = emit_c0 || emit_cn;
    s0.last           = last;
    s0.rep_top        = (c_col == '0) ? (c_row == ROW_W'(2)) : (c_row == ROW_W'(1));
    // left neighbor is the current right column at the left edge of the frame
    s0.left_right_col = ((c_col == '0) && (w_last == '0)) || (c_col == COL_W'(1));
    s0.right_new      = (c_col != '0);

    // advance channel, then column, then row
    col_next = c_col;
    row_next = c_row;
    ch_next  = c_ch + CH_W'(1);
    if (last) begin
      col_next = '0;
      row_next = '0;
      ch_next  = '0;
    end else if (c_ch == ch_max) begin
      ch_next = '0;
      if (c_col == w_last) begin
        col_next = '0;
        row_next = c_row + ROW_W'(1);
      end else begin
        col_next = c_col + COL_W'(1);
      end
    end
  end

  // configuration and position
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= RESET_W_LAST;
      height  <= RESET_HEIGHT;
      color   <= 1'b0;
      col_pos <= '0;
      row_pos <= '0;
      ch_pos  <= '0;
    end else if (cfg_xfer) begin
      case (cfg.addr)
        CFG_FRAME_WIDTH: begin
          if (cfg.data[FWIDTH_W-1:0] == '0) begin
            w_last <= '0;
          end else if (cfg.data[FWIDTH_W-1:0] > FWIDTH_W'(MAX_WIDTH)) begin
            w_last <= COL_W'(MAX_WIDTH - 1);
          end else begin
            w_last <= COL_W'(cfg.data[FWIDTH_W-1:0] - FWIDTH_W'(1));
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg.data == '0) begin
            height <= FHEIGHT_W'(1);
          end else if (cfg.data > FHEIGHT_W'(MAX_HEIGHT)) begin
            height <= FHEIGHT_W'(MAX_HEIGHT);
          end else begin
            height <= cfg.data;
          end
        end
        CFG_COLOR_MODE: begin
          color <= cfg.data[0];
        end
        default: begin
        end
      endcase
      // restart the frame on any listed register
      if (cfg.addr inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_COLOR_MODE}) begin
        col_pos <= '0;
        row_pos <= '0;
        ch_pos  <= '0;
      end
    end else if (in_xfer && !ignore) begin
      col_pos <= col_next;
      row_pos <= row_next;
      ch_pos  <= ch_next;
    end
  end

  // ---------------- stage 1: line stores, window, blur ----------------
  logic [7:0] top, mid, cur;
  colv_t      old_l, old_r, new_col, left_c, right_c;
  logic [7:0] blur_val;

  always_comb begin
    top     = s1_fwd ? s1_fwd_top : rd_top;
    mid     = s1_fwd ? s1_fwd_mid : rd_mid;
    cur     = s1.drain ? mid : s1.sample;  // bottom edge replication on drain
    old_l   = win[s1.ch][1];
    old_r   = win[s1.ch][2];
    new_col = {cur, mid, top};
    left_c  = s1.left_right_col ? old_r : old_l;
    right_c = s1.right_new ? new_col : old_r;
    blur_val = blur(left_c, old_r, right_c, s1.rep_top);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_xfer && !ignore;
    end
  end

  // forward the entry being written when the new item reads the same address
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1         <= s0;
      s1_fwd     <= s1_adv && (s1.idx == idx);
      s1_fwd_top <= mid;
      s1_fwd_mid <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      upper_mem[s1.idx] <= mid;
    end
    if (in_xfer) begin
      rd_top <= upper_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      middle_mem[s1.idx] <= cur;
    end
    if (in_xfer) begin
      rd_mid <= middle_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        for (int k = 0; k < 3; k++) begin
          win[c][k] <= '0;
        end
      end
    end else if (s1_adv) begin
      win[s1.ch][0] <= old_l;
      win[s1.ch][1] <= old_r;
      win[s1.ch][2] <= new_col;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      out_sample <= blur_val;
      out_last   <= s1.last;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.frame_end  = out_last;

endmodule
